// ===== rtl/bsos_pkg.sv =====
// Shared types, constants and helper functions for the beacon seek sequencer.
`default_nettype none

package bsos_pkg;

    // Wait timer width and its limits
    localparam int TIMER_BITS = 10;
    localparam int CMP_W      = (TIMER_BITS > 10) ? TIMER_BITS : 10;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    // Fixed counts
    localparam logic [9:0] PAUSE_TICKS = 10'd10;
    localparam logic [1:0] FLASH_SETS  = 2'd3;
    localparam logic [9:0] EDGE_MAX    = 10'd1023;

    // Config register indexes
    localparam logic [2:0] CFG_OBSTACLE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_TURN_TICKS         = 3'd1;
    localparam logic [2:0] CFG_SEARCH_LIMIT       = 3'd2;
    localparam logic [2:0] CFG_REVERSE_TIME       = 3'd3;
    localparam logic [2:0] CFG_SIDESTEP_TIME      = 3'd4;
    localparam logic [2:0] CFG_CRUISE_TIME        = 3'd5;
    localparam logic [2:0] CFG_LONG_FLASH_HALF    = 3'd6;
    localparam logic [2:0] CFG_SHORT_FLASH_HALF   = 3'd7;

    // H-bridge pin patterns: right one, right two, left one, left two
    localparam logic [3:0] PINS_OFF    = 4'h0;
    localparam logic [3:0] PINS_FWD    = 4'h5;
    localparam logic [3:0] PINS_REV    = 4'hA;
    localparam logic [3:0] PINS_BRAKE  = 4'hF;
    localparam logic [3:0] PINS_SPIN_R = 4'hD;
    localparam logic [3:0] PINS_SPIN_L = 4'h7;

    typedef enum logic [3:0] {
        PH_FLASH_LONG  = 4'd0,
        PH_FLASH_SHORT = 4'd1,
        PH_SEARCH      = 4'd2,
        PH_CHECK       = 4'd3,
        PH_PAUSE       = 4'd4,
        PH_REVERSE     = 4'd5,
        PH_TURN_LEFT   = 4'd6,
        PH_SIDESTEP    = 4'd7,
        PH_TURN_RIGHT  = 4'd8,
        PH_CRUISE      = 4'd9,
        PH_HALT        = 4'd10
    } t_phase;

    typedef struct packed {
        logic [9:0] obstacle_threshold;
        logic [9:0] turn_ticks;
        logic [9:0] search_limit;
        logic [9:0] reverse_time;
        logic [9:0] sidestep_time;
        logic [9:0] cruise_time;
        logic [7:0] long_flash_half;
        logic [7:0] short_flash_half;
    } t_cfg;

    typedef struct packed {
        logic [9:0] left_proximity;
        logic [9:0] right_proximity;
        logic       beacon_left_absent;
        logic       beacon_right_absent;
        logic       encoder_left;
        logic       encoder_right;
        logic       tick_mark;
    } t_sample;

    typedef struct packed {
        logic [3:0] pins;
        logic       leds_on;
        logic       halted;
    } t_result;

    typedef struct packed {
        logic                  done;
        logic [TIMER_BITS-1:0] timer;
    } t_timed;

    // One step of a tick wait of length n (clamped to the timer range)
    function automatic t_timed timed(logic [TIMER_BITS-1:0] timer, logic [9:0] n,
                                     logic tick);
        t_timed           res;
        logic [CMP_W-1:0] n_ext;
        logic [CMP_W-1:0] n_cl;
        logic [CMP_W-1:0] tmax_ext;
        n_ext    = CMP_W'(n);
        tmax_ext = CMP_W'(TMAX);
        n_cl     = (n_ext > tmax_ext) ? tmax_ext : n_ext;
        res.timer = timer;
        if (CMP_W'(timer) >= n_cl) begin
            res.done = 1'b1;
        end else begin
            if (tick && (timer != TMAX)) begin
                res.timer = timer + 1'b1;
            end
            res.done = (CMP_W'(res.timer) >= n_cl);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/beacon_seek_obstacle_sequencer_top.sv =====
// A sample beat is held in the input register and its result beat in the result register.
// Throughput: one sample per cycle unless the result side stalls; the per-sample step is
// one compare, one counter update and a phase change between the two registers.
// Reset (synchronous, active low) empties both registers, loads the config defaults
// and puts the sequencer in its startup long flash with the motors off.
`default_nettype none

module beacon_seek_obstacle_sequencer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [9:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [9:0] i_left_proximity,
    input  wire logic [9:0] i_right_proximity,
    input  wire logic       i_beacon_left_absent,
    input  wire logic       i_beacon_right_absent,
    input  wire logic       i_encoder_left,
    input  wire logic       i_encoder_right,
    input  wire logic       i_tick_mark,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_right_pin_one,
    output logic            o_right_pin_two,
    output logic            o_left_pin_one,
    output logic            o_left_pin_two,
    output logic            o_leds_on,
    output logic            o_halted
);

    bsos_pkg::t_cfg    cfg;
    bsos_pkg::t_sample in_sample;
    bsos_pkg::t_sample held_sample;
    bsos_pkg::t_result step_result;
    bsos_pkg::t_result out_result;
    logic              held_valid;
    logic              advance;

    assign in_sample.left_proximity      = i_left_proximity;
    assign in_sample.right_proximity     = i_right_proximity;
    assign in_sample.beacon_left_absent  = i_beacon_left_absent;
    assign in_sample.beacon_right_absent = i_beacon_right_absent;
    assign in_sample.encoder_left        = i_encoder_left;
    assign in_sample.encoder_right       = i_encoder_right;
    assign in_sample.tick_mark           = i_tick_mark;

    bsos_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bsos_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (in_sample),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_sample  (held_sample)
    );

    bsos_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (held_sample),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    bsos_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (held_valid),
        .i_result   (step_result),
        .o_advance  (advance),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_right_pin_one = out_result.pins[3];
    assign o_right_pin_two = out_result.pins[2];
    assign o_left_pin_one  = out_result.pins[1];
    assign o_left_pin_two  = out_result.pins[0];
    assign o_leds_on       = out_result.leds_on;
    assign o_halted        = out_result.halted;

endmodule

`default_nettype wire

// ===== rtl/bsos_cfg_regs.sv =====
// Configuration register file with reset defaults.
`default_nettype none

module bsos_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    output bsos_pkg::t_cfg   o_cfg
);

    bsos_pkg::t_cfg r_cfg;

    // Register writes, defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_threshold <= 10'd300;
            r_cfg.turn_ticks         <= 10'd156;
            r_cfg.search_limit       <= 10'd936;
            r_cfg.reverse_time       <= 10'd100;
            r_cfg.sidestep_time      <= 10'd120;
            r_cfg.cruise_time        <= 10'd5;
            r_cfg.long_flash_half    <= 8'd50;
            r_cfg.short_flash_half   <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bsos_pkg::CFG_OBSTACLE_THRESHOLD: r_cfg.obstacle_threshold <= i_cfg_data;
                bsos_pkg::CFG_TURN_TICKS:         r_cfg.turn_ticks         <= i_cfg_data;
                bsos_pkg::CFG_SEARCH_LIMIT:       r_cfg.search_limit       <= i_cfg_data;
                bsos_pkg::CFG_REVERSE_TIME:       r_cfg.reverse_time       <= i_cfg_data;
                bsos_pkg::CFG_SIDESTEP_TIME:      r_cfg.sidestep_time      <= i_cfg_data;
                bsos_pkg::CFG_CRUISE_TIME:        r_cfg.cruise_time        <= i_cfg_data;
                bsos_pkg::CFG_LONG_FLASH_HALF:    r_cfg.long_flash_half    <= i_cfg_data[7:0];
                bsos_pkg::CFG_SHORT_FLASH_HALF:   r_cfg.short_flash_half   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/bsos_in_reg.sv =====
// Input register stage for sensor sample beats.
`default_nettype none

module bsos_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bsos_pkg::t_sample i_sample,
    input  wire logic              i_advance,
    output logic                   o_valid,
    output bsos_pkg::t_sample      o_sample
);

    logic              r_valid;
    bsos_pkg::t_sample r_sample;

    // Free when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

// ===== rtl/bsos_core.sv =====
// Sequencer state registers and per-sample next-state logic.
`default_nettype none

module bsos_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire bsos_pkg::t_sample i_sample,
    input  wire bsos_pkg::t_cfg    i_cfg,
    output bsos_pkg::t_result      o_result
);

    bsos_pkg::t_phase                r_phase, n_phase;
    bsos_pkg::t_phase                r_return, n_return;
    logic [bsos_pkg::TIMER_BITS-1:0] r_timer, n_timer;
    logic [9:0]                      r_edge, n_edge;
    logic                            r_last, n_last;
    logic [1:0]                      r_count, n_count;
    logic                            r_lit, n_lit;
    logic [3:0]                      r_pins, n_pins;
    logic                            r_stopped, n_stopped;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bsos_pkg::PH_FLASH_LONG;
            r_return  <= bsos_pkg::PH_SEARCH;
            r_timer   <= '0;
            r_edge    <= '0;
            r_last    <= 1'b0;
            r_count   <= '0;
            r_lit     <= 1'b1;
            r_pins    <= bsos_pkg::PINS_OFF;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_return  <= n_return;
            r_timer   <= n_timer;
            r_edge    <= n_edge;
            r_last    <= n_last;
            r_count   <= n_count;
            r_lit     <= n_lit;
            r_pins    <= n_pins;
            r_stopped <= n_stopped;
        end
    end

    // Next state and result for the current sample
    always_comb begin
        bsos_pkg::t_timed tw;
        bsos_pkg::t_phase enter_to;
        logic             do_enter;
        logic             leds;
        logic             enc;
        logic [9:0]       cnt;
        logic             obstacle;
        logic             both_absent;

        n_phase   = r_phase;
        n_return  = r_return;
        n_timer   = r_timer;
        n_edge    = r_edge;
        n_last    = r_last;
        n_count   = r_count;
        n_lit     = r_lit;
        n_pins    = r_pins;
        n_stopped = r_stopped;
        do_enter  = 1'b0;
        enter_to  = bsos_pkg::PH_HALT;
        leds      = 1'b0;
        tw        = '0;
        enc       = 1'b0;
        cnt       = r_edge;
        obstacle  = (i_sample.left_proximity >= i_cfg.obstacle_threshold) ||
                    (i_sample.right_proximity >= i_cfg.obstacle_threshold);
        both_absent = i_sample.beacon_left_absent && i_sample.beacon_right_absent;

        case (r_phase)
            bsos_pkg::PH_FLASH_LONG, bsos_pkg::PH_FLASH_SHORT: begin
                tw = bsos_pkg::timed(r_timer,
                    (r_phase == bsos_pkg::PH_FLASH_LONG) ? {2'b00, i_cfg.long_flash_half}
                                                         : {2'b00, i_cfg.short_flash_half},
                    i_sample.tick_mark);
                n_timer = tw.timer;
                leds    = r_lit;
                if (tw.done) begin
                    n_timer = '0;
                    if (r_lit) begin
                        n_lit = 1'b0;
                        leds  = 1'b0;
                    end else if (r_count + 2'd1 >= bsos_pkg::FLASH_SETS) begin
                        do_enter = 1'b1;
                        enter_to = r_return;
                        leds     = 1'b0;
                    end else begin
                        n_count = r_count + 2'd1;
                        n_lit   = 1'b1;
                        leds    = 1'b1;
                    end
                end
            end
            bsos_pkg::PH_SEARCH: begin
                if (i_sample.beacon_left_absent || i_sample.beacon_right_absent) begin
                    n_pins = i_sample.beacon_left_absent ? bsos_pkg::PINS_SPIN_R
                                                         : bsos_pkg::PINS_SPIN_L;
                    n_last = i_sample.encoder_left;
                    if ((i_sample.encoder_left != r_last) && (r_edge != bsos_pkg::EDGE_MAX)) begin
                        cnt = r_edge + 10'd1;
                    end
                    n_edge = cnt;
                    if (cnt > i_cfg.search_limit) begin
                        n_return = bsos_pkg::PH_HALT;
                        do_enter = 1'b1;
                        enter_to = bsos_pkg::PH_FLASH_LONG;
                        leds     = 1'b1;
                    end
                end else begin
                    do_enter = 1'b1;
                    enter_to = bsos_pkg::PH_CHECK;
                end
            end
            bsos_pkg::PH_CHECK: begin
                do_enter = 1'b1;
                if (obstacle) begin
                    n_pins   = bsos_pkg::PINS_BRAKE;
                    n_return = both_absent ? bsos_pkg::PH_HALT : bsos_pkg::PH_PAUSE;
                    enter_to = both_absent ? bsos_pkg::PH_FLASH_LONG
                                           : bsos_pkg::PH_FLASH_SHORT;
                    leds     = 1'b1;
                end else begin
                    n_pins   = bsos_pkg::PINS_FWD;
                    enter_to = bsos_pkg::PH_CRUISE;
                end
            end
            bsos_pkg::PH_PAUSE: begin
                n_pins  = bsos_pkg::PINS_BRAKE;
                tw      = bsos_pkg::timed(r_timer, bsos_pkg::PAUSE_TICKS, i_sample.tick_mark);
                n_timer = tw.timer;
                if (tw.done) begin
                    do_enter = 1'b1;
                    enter_to = bsos_pkg::PH_REVERSE;
                end
            end
            bsos_pkg::PH_REVERSE: begin
                n_pins  = bsos_pkg::PINS_REV;
                tw      = bsos_pkg::timed(r_timer, i_cfg.reverse_time, i_sample.tick_mark);
                n_timer = tw.timer;
                if (tw.done) begin
                    do_enter = 1'b1;
                    enter_to = bsos_pkg::PH_TURN_LEFT;
                end
            end
            bsos_pkg::PH_TURN_LEFT, bsos_pkg::PH_TURN_RIGHT: begin
                // Left turn watches the right wheel, right turn the left wheel
                enc = (r_phase == bsos_pkg::PH_TURN_LEFT) ? i_sample.encoder_right
                                                          : i_sample.encoder_left;
                if (r_edge < i_cfg.turn_ticks) begin
                    n_pins = (r_phase == bsos_pkg::PH_TURN_LEFT) ? bsos_pkg::PINS_SPIN_L
                                                                 : bsos_pkg::PINS_SPIN_R;
                    n_last = enc;
                    if ((enc != r_last) && (r_edge != bsos_pkg::EDGE_MAX)) begin
                        cnt = r_edge + 10'd1;
                    end
                    n_edge = cnt;
                end
                if (cnt >= i_cfg.turn_ticks) begin
                    n_pins   = bsos_pkg::PINS_BRAKE;
                    do_enter = 1'b1;
                    enter_to = (r_phase == bsos_pkg::PH_TURN_LEFT) ? bsos_pkg::PH_SIDESTEP
                                                                   : bsos_pkg::PH_SEARCH;
                end
            end
            bsos_pkg::PH_SIDESTEP: begin
                n_pins  = bsos_pkg::PINS_FWD;
                tw      = bsos_pkg::timed(r_timer, i_cfg.sidestep_time, i_sample.tick_mark);
                n_timer = tw.timer;
                if (tw.done) begin
                    do_enter = 1'b1;
                    enter_to = bsos_pkg::PH_TURN_RIGHT;
                end
            end
            bsos_pkg::PH_CRUISE: begin
                n_pins  = bsos_pkg::PINS_FWD;
                tw      = bsos_pkg::timed(r_timer, i_cfg.cruise_time, i_sample.tick_mark);
                n_timer = tw.timer;
                if (tw.done) begin
                    do_enter = 1'b1;
                    enter_to = bsos_pkg::PH_SEARCH;
                end
            end
            default: begin
                // Halted for good
                n_phase   = bsos_pkg::PH_HALT;
                n_pins    = bsos_pkg::PINS_BRAKE;
                n_stopped = 1'b1;
            end
        endcase

        // Phase entry: clear counters, capture watched encoder level, restart a flash, brake on halt
        if (do_enter) begin
            n_phase = enter_to;
            n_timer = '0;
            n_edge  = '0;
            n_last  = (enter_to == bsos_pkg::PH_TURN_LEFT) ? i_sample.encoder_right
                                                           : i_sample.encoder_left;
            if ((enter_to == bsos_pkg::PH_FLASH_LONG) ||
                (enter_to == bsos_pkg::PH_FLASH_SHORT)) begin
                n_count = '0;
                n_lit   = 1'b1;
            end
            if (enter_to == bsos_pkg::PH_HALT) begin
                n_stopped = 1'b1;
                n_pins    = bsos_pkg::PINS_BRAKE;
            end
        end

        o_result.pins    = n_pins;
        o_result.leds_on = leds;
        o_result.halted  = n_stopped;
    end

endmodule

`default_nettype wire

// ===== rtl/bsos_out_reg.sv =====
// Output result register holding one result beat.
`default_nettype none

module bsos_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire bsos_pkg::t_result i_result,
    output logic                   o_advance,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bsos_pkg::t_result      o_result
);

    logic              r_valid;
    bsos_pkg::t_result r_result;

    // A held sample moves on when the slot is empty or being drained
    assign o_advance = i_in_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the beacon seek and obstacle avoid sequencer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsos_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    typedef enum bit {HALT_BY_ABORT, HALT_BY_LOST} halt_path_e;

    // Tracks the robot's sequencer state and the result beats still owed by the block
    class robot_tracker;
        t_cfg                  cfg;
        t_phase                phase;
        t_phase                ret_phase;
        logic [TIMER_BITS-1:0] tmr;
        logic [9:0]            edges;
        logic                  last_enc;
        logic [1:0]            flashes;
        logic                  lit;
        logic [3:0]            pins;
        logic                  stopped;
        logic [15:0]           seen;
        t_result               outputs_owed[$];
        int                    errors;
        int                    matched;

        function new();
            cfg.obstacle_threshold = 10'd300;
            cfg.turn_ticks         = 10'd156;
            cfg.search_limit       = 10'd936;
            cfg.reverse_time       = 10'd100;
            cfg.sidestep_time      = 10'd120;
            cfg.cruise_time        = 10'd5;
            cfg.long_flash_half    = 8'd50;
            cfg.short_flash_half   = 8'd16;
            phase     = PH_FLASH_LONG;
            ret_phase = PH_SEARCH;
            tmr       = '0;
            edges     = '0;
            last_enc  = 1'b0;
            flashes   = '0;
            lit       = 1'b1;
            pins      = PINS_OFF;
            stopped   = 1'b0;
            seen      = '0;
            errors    = 0;
            matched   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [9:0] data);
            case (idx)
                CFG_OBSTACLE_THRESHOLD: cfg.obstacle_threshold = data;
                CFG_TURN_TICKS:         cfg.turn_ticks = data;
                CFG_SEARCH_LIMIT:       cfg.search_limit = data;
                CFG_REVERSE_TIME:       cfg.reverse_time = data;
                CFG_SIDESTEP_TIME:      cfg.sidestep_time = data;
                CFG_CRUISE_TIME:        cfg.cruise_time = data;
                CFG_LONG_FLASH_HALF:    cfg.long_flash_half = data[7:0];
                CFG_SHORT_FLASH_HALF:   cfg.short_flash_half = data[7:0];
                default: ;
            endcase
        endfunction

        // Tick wait: true once the ticks have brought the timer to n, clamped to the timer range
        function bit wait_done(logic [9:0] n, bit tick);
            int unsigned cap;
            int unsigned lim;
            cap = int'(TMAX);
            lim = (int'(n) > cap) ? cap : int'(n);
            if (tmr >= lim) return 1'b1;
            if (tick && tmr < cap) tmr = tmr + 1'b1;
            return tmr >= lim;
        endfunction

        function void count_edge(logic enc);
            if (enc != last_enc && edges < EDGE_MAX) edges = edges + 1'b1;
            last_enc = enc;
        endfunction

        function void enter(t_phase next, logic el, logic er);
            phase    = next;
            tmr      = '0;
            edges    = '0;
            last_enc = (next == PH_TURN_LEFT) ? er : el;
            if (next == PH_FLASH_LONG || next == PH_FLASH_SHORT) begin
                flashes = '0;
                lit     = 1'b1;
            end
            if (next == PH_HALT) begin
                stopped = 1'b1;
                pins    = PINS_BRAKE;
            end
        endfunction

        // One sample through the sequencer
        function t_result advance(t_sample s);
            t_result    r;
            logic       leds;
            logic       el;
            logic       er;
            bit         tick;
            bit         left;
            bit         leaving;
            bit         both_absent;
            logic [9:0] half;
            el          = s.encoder_left;
            er          = s.encoder_right;
            tick        = s.tick_mark;
            leds        = 1'b0;
            leaving     = 1'b0;
            both_absent = s.beacon_left_absent && s.beacon_right_absent;
            seen[phase] = 1'b1;
            case (phase)
                PH_FLASH_LONG, PH_FLASH_SHORT: begin
                    half = (phase == PH_FLASH_LONG) ? 10'(cfg.long_flash_half)
                                                    : 10'(cfg.short_flash_half);
                    if (wait_done(half, tick)) begin
                        tmr = '0;
                        if (lit) begin
                            lit = 1'b0;
                        end else if (int'(flashes) + 1 >= int'(FLASH_SETS)) begin
                            enter(ret_phase, el, er);
                            leaving = 1'b1;
                        end else begin
                            flashes = flashes + 1'b1;
                            lit     = 1'b1;
                        end
                    end
                    if (!leaving) leds = lit;
                end
                PH_SEARCH: begin
                    if (s.beacon_left_absent || s.beacon_right_absent) begin
                        pins = s.beacon_left_absent ? PINS_SPIN_R : PINS_SPIN_L;
                        count_edge(el);
                        if (edges > cfg.search_limit) begin
                            ret_phase = PH_HALT;
                            enter(PH_FLASH_LONG, el, er);
                            leds = lit;
                        end
                    end else begin
                        enter(PH_CHECK, el, er);
                    end
                end
                PH_CHECK: begin
                    if (s.left_proximity >= cfg.obstacle_threshold ||
                        s.right_proximity >= cfg.obstacle_threshold) begin
                        pins      = PINS_BRAKE;
                        ret_phase = both_absent ? PH_HALT : PH_PAUSE;
                        enter(both_absent ? PH_FLASH_LONG : PH_FLASH_SHORT, el, er);
                        leds = lit;
                    end else begin
                        pins = PINS_FWD;
                        enter(PH_CRUISE, el, er);
                    end
                end
                PH_PAUSE: begin
                    pins = PINS_BRAKE;
                    if (wait_done(PAUSE_TICKS, tick)) enter(PH_REVERSE, el, er);
                end
                PH_REVERSE: begin
                    pins = PINS_REV;
                    if (wait_done(cfg.reverse_time, tick)) enter(PH_TURN_LEFT, el, er);
                end
                PH_TURN_LEFT, PH_TURN_RIGHT: begin
                    left = (phase == PH_TURN_LEFT);
                    if (edges < cfg.turn_ticks) begin
                        pins = left ? PINS_SPIN_L : PINS_SPIN_R;
                        count_edge(left ? er : el);
                    end
                    if (edges >= cfg.turn_ticks) begin
                        pins = PINS_BRAKE;
                        enter(left ? PH_SIDESTEP : PH_SEARCH, el, er);
                    end
                end
                PH_SIDESTEP: begin
                    pins = PINS_FWD;
                    if (wait_done(cfg.sidestep_time, tick)) enter(PH_TURN_RIGHT, el, er);
                end
                PH_CRUISE: begin
                    pins = PINS_FWD;
                    if (wait_done(cfg.cruise_time, tick)) enter(PH_SEARCH, el, er);
                end
                default: begin
                    phase   = PH_HALT;
                    pins    = PINS_BRAKE;
                    stopped = 1'b1;
                end
            endcase
            r.pins    = pins;
            r.leds_on = leds;
            r.halted  = stopped;
            return r;
        endfunction

        function void log_sample(t_sample s);
            outputs_owed.push_back(advance(s));
        endfunction

        function void check_outputs(t_result got);
            t_result    want;
            logic [5:0] w;
            logic [5:0] g;
            string      field_name[6] = '{"halted", "leds_on", "left_pin_two",
                                          "left_pin_one", "right_pin_two",
                                          "right_pin_one"};
            if (outputs_owed.size() == 0) begin
                $display("%0t: result beat with nothing owed, actual pins %b leds %b halted %b",
                         $time, got.pins, got.leds_on, got.halted);
                errors++;
                return;
            end
            want = outputs_owed.pop_front();
            w = want;
            g = got;
            for (int k = 0; k < 6; k++) begin
                if (w[k] !== g[k]) begin
                    $display("%0t: %s expected %b actual %b", $time, field_name[k], w[k], g[k]);
                    errors++;
                end
            end
            matched++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [9:0] i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic [9:0] i_left_proximity;
    logic [9:0] i_right_proximity;
    logic       i_beacon_left_absent;
    logic       i_beacon_right_absent;
    logic       i_encoder_left;
    logic       i_encoder_right;
    logic       i_tick_mark;
    logic       o_valid;
    logic       i_ready;
    logic       o_right_pin_one;
    logic       o_right_pin_two;
    logic       o_left_pin_one;
    logic       o_left_pin_two;
    logic       o_leds_on;
    logic       o_halted;

    robot_tracker robot = new();

    int         send_idle_pct;
    int         stall_pct;
    bit         hold_req;
    bit         halt_ok;
    halt_path_e halt_kind;
    int         samples_sent;
    int         cycles;

    beacon_seek_obstacle_sequencer_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_left_proximity      (i_left_proximity),
        .i_right_proximity     (i_right_proximity),
        .i_beacon_left_absent  (i_beacon_left_absent),
        .i_beacon_right_absent (i_beacon_right_absent),
        .i_encoder_left        (i_encoder_left),
        .i_encoder_right       (i_encoder_right),
        .i_tick_mark           (i_tick_mark),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_right_pin_one       (o_right_pin_one),
        .o_right_pin_two       (o_right_pin_two),
        .o_left_pin_one        (o_left_pin_one),
        .o_left_pin_two        (o_left_pin_two),
        .o_leds_on             (o_leds_on),
        .o_halted              (o_halted)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run length guard
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d result beats still owed",
                 $time, cycles, robot.outputs_owed.size());
        $display("FAIL beacon_seek_obstacle_sequencer_top");
        $finish;
    end

    // Result side backpressure, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Result beats checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            robot.check_outputs({o_right_pin_one, o_right_pin_two, o_left_pin_one,
                                 o_left_pin_two, o_leds_on, o_halted});
        end
    end

    // Proximity reading: threshold edges, extremes and plenty of clear readings
    function automatic logic [9:0] pick_prox(int thr);
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 1023);
            1: v = thr + $urandom_range(0, 2) - 1;
            2: v = $urandom_range(0, 1) ? 1023 : 0;
            default: v = (thr > 0) ? $urandom_range(0, thr - 1) : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    // Next sample, steered away from halting until the last stretch of the run
    function automatic t_sample pick_sample();
        t_sample s;
        bit      abort_ok;
        bit      lost_ok;
        int      thr;
        abort_ok = halt_ok && (halt_kind == HALT_BY_ABORT);
        lost_ok  = halt_ok && (halt_kind == HALT_BY_LOST);
        thr      = int'(robot.cfg.obstacle_threshold);
        s.left_proximity  = pick_prox(thr);
        s.right_proximity = pick_prox(thr);
        s.encoder_left    = 1'($urandom_range(0, 1));
        s.encoder_right   = 1'($urandom_range(0, 1));
        s.tick_mark       = ($urandom_range(0, 99) < 65);
        if ($urandom_range(0, 99) < 30) begin
            s.beacon_left_absent  = 1'b0;
            s.beacon_right_absent = 1'b0;
        end else begin
            s.beacon_left_absent  = 1'($urandom_range(0, 1));
            s.beacon_right_absent = 1'($urandom_range(0, 1));
        end
        if (robot.phase == PH_SEARCH) begin
            if (abort_ok) begin
                s.beacon_left_absent = 1'b1;
                s.encoder_left       = ~robot.last_enc;
            end else if (robot.edges > robot.cfg.search_limit) begin
                s.beacon_left_absent  = 1'b0;
                s.beacon_right_absent = 1'b0;
            end else if (robot.edges == robot.cfg.search_limit) begin
                s.encoder_left = robot.last_enc;
            end
        end
        if (robot.phase == PH_CHECK) begin
            if (lost_ok) begin
                s.left_proximity      = 10'd1023;
                s.beacon_left_absent  = 1'b1;
                s.beacon_right_absent = 1'b1;
            end else if ((s.left_proximity >= thr || s.right_proximity >= thr) &&
                         s.beacon_left_absent && s.beacon_right_absent) begin
                if ($urandom_range(0, 1)) s.beacon_left_absent = 1'b0;
                else s.beacon_right_absent = 1'b0;
            end
        end
        return s;
    endfunction

    // Short waits and turns so that the whole avoidance loop keeps coming round
    function automatic t_cfg small_settings();
        t_cfg c;
        c.obstacle_threshold = 10'($urandom_range(100, 1000));
        c.turn_ticks         = 10'($urandom_range(0, 6));
        c.search_limit       = ($urandom_range(0, 3) == 0) ? 10'd1023
                                                            : 10'($urandom_range(0, 24));
        c.reverse_time       = 10'($urandom_range(0, 5));
        c.sidestep_time      = 10'($urandom_range(0, 5));
        c.cruise_time        = 10'($urandom_range(0, 4));
        c.long_flash_half    = 8'($urandom_range(0, 3));
        c.short_flash_half   = 8'($urandom_range(0, 3));
        return c;
    endfunction

    // One register write; enable is dropped by the caller
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        robot.set_reg(idx, data);
    endtask

    // Full register set; spare upper bits on the 8-bit registers carry junk
    task automatic load_settings(input t_cfg c);
        write_reg(CFG_OBSTACLE_THRESHOLD, c.obstacle_threshold);
        write_reg(CFG_TURN_TICKS, c.turn_ticks);
        write_reg(CFG_SEARCH_LIMIT, c.search_limit);
        write_reg(CFG_REVERSE_TIME, c.reverse_time);
        write_reg(CFG_SIDESTEP_TIME, c.sidestep_time);
        write_reg(CFG_CRUISE_TIME, c.cruise_time);
        write_reg(CFG_LONG_FLASH_HALF, {2'($urandom_range(0, 3)), c.long_flash_half});
        write_reg(CFG_SHORT_FLASH_HALF, {2'($urandom_range(0, 3)), c.short_flash_half});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample beat; called and returns at a falling edge
    task automatic offer(input t_sample s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid               <= 1'b1;
        i_left_proximity      <= s.left_proximity;
        i_right_proximity     <= s.right_proximity;
        i_beacon_left_absent  <= s.beacon_left_absent;
        i_beacon_right_absent <= s.beacon_right_absent;
        i_encoder_left        <= s.encoder_left;
        i_encoder_right       <= s.encoder_right;
        i_tick_mark           <= s.tick_mark;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        robot.log_sample(s);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every owed result beat
    task automatic drain();
        i_valid <= 1'b0;
        while (robot.outputs_owed.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_sample s;
        t_cfg    c;
        int      tail;
        int      n;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        i_valid               = 1'b0;
        i_left_proximity      = '0;
        i_right_proximity     = '0;
        i_beacon_left_absent  = 1'b0;
        i_beacon_right_absent = 1'b0;
        i_encoder_left        = 1'b0;
        i_encoder_right       = 1'b0;
        i_tick_mark           = 1'b0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        hold_req              = 1'b0;
        halt_ok               = 1'b0;
        halt_kind             = HALT_BY_ABORT;
        samples_sent          = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes and threshold edges during the startup flash
        for (int i = 0; i < 20; i++) begin
            s = pick_sample();
            case (i % 4)
                0: s = '0;
                1: s = '1;
                2: begin
                    s.left_proximity  = robot.cfg.obstacle_threshold - 1'b1;
                    s.right_proximity = robot.cfg.obstacle_threshold;
                end
                default: ;
            endcase
            offer(s);
        end

        // Random phases: all-zero settings, all-ones settings, then short sequences
        for (int p = 0; p < 8; p++) begin
            drain();
            case (p)
                0: c = '0;
                1: c = '1;
                default: c = small_settings();
            endcase
            load_settings(c);
            send_idle_pct = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 29 : 0;
            stall_pct     = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 29 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 4 && i == 40) hold_req = 1'b1;
                offer(pick_sample());
            end
        end

        // Last stretch: let one halt path fire, then check the halted block ignores input
        drain();
        c = small_settings();
        c.search_limit = 10'($urandom_range(0, 3));
        load_settings(c);
        halt_kind     = halt_path_e'($urandom_range(0, 1));
        halt_ok       = 1'b1;
        send_idle_pct = 29;
        stall_pct     = 29;
        tail = 0;
        n    = 0;
        while (tail < 30 && n < 800) begin
            offer(pick_sample());
            n++;
            if (robot.stopped) tail++;
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d sample beats and %0d checked result beats over %0d phases,",
                 samples_sent, robot.matched, $countones(robot.seen));
        $display("nine register settings with idle and stall mixes, ending in a %s halt.",
                 (halt_kind == HALT_BY_ABORT) ? "search abort" : "beacon lost");
        if (robot.errors == 0) begin
            $display("PASS beacon_seek_obstacle_sequencer_top");
        end else begin
            $display("FAIL beacon_seek_obstacle_sequencer_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bsos_pkg.sv
rtl/bsos_cfg_regs.sv
rtl/bsos_in_reg.sv
rtl/bsos_core.sv
rtl/bsos_out_reg.sv
rtl/beacon_seek_obstacle_sequencer_top.sv
tb/tb_top.sv
